// File: rtl/eav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eav_pkg
// Shared constants, widths and the arctangent table of the elliptical arc
// vertex generator.
// ----------------------------------------------------------------------------
package eav_pkg;

	// defaults of the top level parameters
	localparam int MAX_POINTS_DEF   = 4096;
	localparam int CORDIC_STEPS_DEF = 24;

	// field widths
	localparam int IDX_W  = 13;   // vertex index and point count
	localparam int SPAN_W = 31;   // angular span, also divider quotient
	localparam int NUM_W  = IDX_W + SPAN_W;   // dividend index * span + n/2
	localparam int ANG_W  = 35;   // angle during reduction
	localparam int CW     = 34;   // cordic datapath
	localparam int CRD_W  = 32;   // coordinates, Q16.16
	localparam int SUM_W  = 35;   // centre plus radius term, Q16.17
	localparam int DAT_W  = 32;   // configuration write data
	localparam int REG_W  = 3;    // configuration register index

	// configuration register indexes
	localparam logic [REG_W-1:0] REG_ANCHOR_MODE = 3'd0;
	localparam logic [REG_W-1:0] REG_ANCHOR_X    = 3'd1;
	localparam logic [REG_W-1:0] REG_ANCHOR_Y    = 3'd2;
	localparam logic [REG_W-1:0] REG_BOX_WIDTH   = 3'd3;
	localparam logic [REG_W-1:0] REG_BOX_HEIGHT  = 3'd4;
	localparam logic [REG_W-1:0] REG_POINT_COUNT = 3'd5;
	localparam logic [REG_W-1:0] REG_START_ANGLE = 3'd6;
	localparam logic [REG_W-1:0] REG_END_ANGLE   = 3'd7;

	// anchor modes
	localparam logic [1:0] MODE_BASE   = 2'd0;
	localparam logic [1:0] MODE_CENTRE = 2'd1;
	localparam logic [1:0] MODE_ORIGIN = 2'd2;

	// angle constants, Q6.28
	localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 35'sd1686629713;
	localparam logic signed [ANG_W-1:0] PI_Q28      = 35'sd843314857;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 35'sd421657428;

	// cordic start vector, Q30
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// truncated arctangent of 2^-i, Q30
	function automatic logic [31:0] atan_q30(input int unsigned i);
		logic [31:0] v;
		case (i)
			0:  v = 32'h3243F6A8;
			1:  v = 32'h1DAC6705;
			2:  v = 32'h0FADBAFC;
			3:  v = 32'h07F56EA6;
			4:  v = 32'h03FEAB76;
			5:  v = 32'h01FFD55B;
			6:  v = 32'h00FFFAAA;
			7:  v = 32'h007FFF55;
			8:  v = 32'h003FFFEA;
			9:  v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			24: v = 32'h0000003F;
			25: v = 32'h0000001F;
			26: v = 32'h0000000F;
			27: v = 32'h00000008;
			28: v = 32'h00000004;
			29: v = 32'h00000002;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: rtl/eav_angle.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eav_angle
// Vertex index to cordic angle: index * span, restoring divide by the point
// count one quotient bit a stage, then reduction into [-pi/2, pi/2].
// ----------------------------------------------------------------------------
module eav_angle #(
	parameter int MAX_POINTS = eav_pkg::MAX_POINTS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic [eav_pkg::IDX_W-1:0]           in_index,
	input  wire logic [eav_pkg::IDX_W-1:0]           point_count,
	input  wire logic [eav_pkg::SPAN_W-1:0]          span,
	input  wire logic signed [31:0]                  start_angle,
	output logic                                     out_valid,
	output logic signed [eav_pkg::CW-1:0]            out_z,
	output logic                                     out_neg
);

	localparam int QW      = eav_pkg::SPAN_W;
	localparam int NUM_W   = eav_pkg::NUM_W;
	localparam int ANG_W   = eav_pkg::ANG_W;
	localparam int IDX_W   = eav_pkg::IDX_W;
	localparam int CW      = eav_pkg::CW;
	localparam int ANG_LAT = QW + 6;

	localparam logic [ANG_W-1:0] T1 = eav_pkg::TWO_PI_Q28;
	localparam logic [ANG_W-1:0] T2 = ANG_W'(2 * 64'(eav_pkg::TWO_PI_Q28));
	localparam logic [ANG_W-1:0] T4 = ANG_W'(4 * 64'(eav_pkg::TWO_PI_Q28));

	logic [IDX_W-1:0] n_c;
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] idx_c;
	logic [IDX_W-1:0] idx_s1;
	logic [ANG_LAT-1:0] vld_s;
	logic [NUM_W-1:0] rem_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic [ANG_W-1:0] r0_s34;
	logic [ANG_W-1:0] r1_s35;
	logic signed [ANG_W-1:0] r2_s36;
	logic signed [CW-1:0] z_s37;
	logic neg_s37;

	// effective point count, kept for the divider
	always_comb begin
		if (point_count == '0) begin
			n_c = IDX_W'(1);
		end else if (32'(point_count) > 32'(MAX_POINTS)) begin
			n_c = IDX_W'(MAX_POINTS);
		end else begin
			n_c = point_count;
		end
	end

	assign idx_c = (in_index >= n_c) ? '0 : in_index;

	always_ff @(posedge clk) begin
		n_q <= n_c;
	end

	// valid bits of all stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[ANG_LAT-2:0], in_valid};
		end
	end

	// index capture and dividend with rounding term
	always_ff @(posedge clk) begin
		idx_s1   <= idx_c;
		rem_s[0] <= NUM_W'(idx_s1) * NUM_W'(span) + NUM_W'(n_q >> 1);
		quo_s[0] <= '0;
	end

	// restoring divider, one quotient bit a stage
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		logic [NUM_W-1:0] dsor;
		assign dsor = NUM_W'(n_q) << K;
		always_ff @(posedge clk) begin
			if (rem_s[j] >= dsor) begin
				rem_s[j+1] <= rem_s[j] - dsor;
				quo_s[j+1] <= {quo_s[j][QW-2:0], 1'b1};
			end else begin
				rem_s[j+1] <= rem_s[j];
				quo_s[j+1] <= {quo_s[j][QW-2:0], 1'b0};
			end
		end
	end

	// angle plus two turns, always positive and below eight turns
	always_ff @(posedge clk) begin
		r0_s34 <= ANG_W'(signed'(start_angle)) + ANG_W'(quo_s[QW]) + T2;
	end

	// modulo two pi, coarse steps
	always_ff @(posedge clk) begin
		logic [ANG_W-1:0] a;
		a = (r0_s34 >= T4) ? r0_s34 - T4 : r0_s34;
		r1_s35 <= (a >= T2) ? a - T2 : a;
	end

	// last modulo step, then into (-pi, pi]
	always_ff @(posedge clk) begin
		logic signed [ANG_W-1:0] b;
		b = signed'((r1_s35 >= T1) ? r1_s35 - T1 : r1_s35);
		r2_s36 <= (b > eav_pkg::PI_Q28) ? b - eav_pkg::TWO_PI_Q28 : b;
	end

	// fold into [-pi/2, pi/2] and scale to Q30
	always_ff @(posedge clk) begin
		logic signed [ANG_W-1:0] f;
		logic ng;
		if (r2_s36 > eav_pkg::HALF_PI_Q28) begin
			f  = r2_s36 - eav_pkg::PI_Q28;
			ng = 1'b1;
		end else if (r2_s36 < -eav_pkg::HALF_PI_Q28) begin
			f  = r2_s36 + eav_pkg::PI_Q28;
			ng = 1'b1;
		end else begin
			f  = r2_s36;
			ng = 1'b0;
		end
		z_s37   <= {f[CW-3:0], 2'b00};
		neg_s37 <= ng;
	end

	assign out_valid = vld_s[ANG_LAT-1];
	assign out_z     = z_s37;
	assign out_neg   = neg_s37;

endmodule
`default_nettype wire

// File: rtl/eav_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eav_cordic
// Rotation-mode cordic, one micro-rotation per pipeline stage.
// ----------------------------------------------------------------------------
module eav_cordic #(
	parameter int STEPS = eav_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic signed [eav_pkg::CW-1:0]  in_z,
	input  wire logic                           in_neg,
	output logic                                out_valid,
	output logic signed [eav_pkg::CW-1:0]       out_x,
	output logic signed [eav_pkg::CW-1:0]       out_y,
	output logic                                out_neg
);

	localparam int CW = eav_pkg::CW;

	logic [STEPS-1:0] vld_s;
	logic signed [CW-1:0] x_s [0:STEPS];
	logic signed [CW-1:0] y_s [0:STEPS];
	logic signed [CW-1:0] z_s [0:STEPS];
	logic neg_s [0:STEPS];

	assign x_s[0]   = eav_pkg::CORDIC_GAIN_Q30;
	assign y_s[0]   = '0;
	assign z_s[0]   = in_z;
	assign neg_s[0] = in_neg;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[STEPS-2:0], in_valid};
		end
	end

	// micro-rotations
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [CW-1:0] ATAN = CW'(eav_pkg::atan_q30(i));
		always_ff @(posedge clk) begin
			if (!z_s[i][CW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN;
			end
			neg_s[i+1] <= neg_s[i];
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_x     = x_s[STEPS];
	assign out_y     = y_s[STEPS];
	assign out_neg   = neg_s[STEPS];

endmodule
`default_nettype wire

// File: rtl/eav_coord.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eav_coord
// Scales cosine and sine by the box extents, adds the centre, rounds to
// Q16.16 and saturates.
// ----------------------------------------------------------------------------
module eav_coord (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic signed [eav_pkg::CW-1:0]     in_x,
	input  wire logic signed [eav_pkg::CW-1:0]     in_y,
	input  wire logic                              in_neg,
	input  wire logic [30:0]                       box_width,
	input  wire logic [30:0]                       box_height,
	input  wire logic signed [eav_pkg::CW-1:0]     centre_x2,
	input  wire logic signed [eav_pkg::CW-1:0]     centre_y2,
	output logic                                   out_valid,
	output logic signed [eav_pkg::CRD_W-1:0]       out_x,
	output logic signed [eav_pkg::CRD_W-1:0]       out_y,
	output logic                                   out_sat
);

	localparam int CRD_W = eav_pkg::CRD_W;
	localparam int SUM_W = eav_pkg::SUM_W;
	localparam logic signed [SUM_W-1:0] POS_MAX = 35'sd2147483647;
	localparam logic signed [SUM_W-1:0] NEG_MAX = -35'sd2147483648;
	localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

	logic [3:0] vld_s;
	logic signed [CRD_W-1:0] c_s1, s_s1;
	logic signed [63:0] px_s2, py_s2;
	logic signed [SUM_W-1:0] sx_s3, sy_s3;
	logic signed [CRD_W-1:0] x_s4, y_s4;
	logic sat_s4;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[2:0], in_valid};
		end
	end

	// undo the half-turn fold
	always_ff @(posedge clk) begin
		c_s1 <= CRD_W'(in_neg ? -in_x : in_x);
		s_s1 <= CRD_W'(in_neg ? -in_y : in_y);
	end

	// radius terms
	always_ff @(posedge clk) begin
		px_s2 <= $signed({1'b0, box_width}) * c_s1;
		py_s2 <= $signed({1'b0, box_height}) * s_s1;
	end

	// round to Q16.17 and add the centre
	always_ff @(posedge clk) begin
		sx_s3 <= SUM_W'(centre_x2) + SUM_W'((px_s2 + HALF_Q30) >>> 30);
		sy_s3 <= SUM_W'(centre_y2) + SUM_W'((py_s2 + HALF_Q30) >>> 30);
	end

	// round to Q16.16 and clamp
	always_ff @(posedge clk) begin
		logic signed [SUM_W-1:0] vx, vy;
		logic hx, hy;
		vx = (sx_s3 + SUM_W'(1)) >>> 1;
		vy = (sy_s3 + SUM_W'(1)) >>> 1;
		hx = (vx > POS_MAX) || (vx < NEG_MAX);
		hy = (vy > POS_MAX) || (vy < NEG_MAX);
		if (vx > POS_MAX) begin
			x_s4 <= CRD_W'(POS_MAX);
		end else if (vx < NEG_MAX) begin
			x_s4 <= CRD_W'(NEG_MAX);
		end else begin
			x_s4 <= CRD_W'(vx);
		end
		if (vy > POS_MAX) begin
			y_s4 <= CRD_W'(POS_MAX);
		end else if (vy < NEG_MAX) begin
			y_s4 <= CRD_W'(NEG_MAX);
		end else begin
			y_s4 <= CRD_W'(vy);
		end
		sat_s4 <= hx | hy;
	end

	assign out_valid = vld_s[3];
	assign out_x     = x_s4;
	assign out_y     = y_s4;
	assign out_sat   = sat_s4;

endmodule
`default_nettype wire

// File: rtl/ellipse_arc_vertex_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ellipse_arc_vertex_generator_unit
// Returns one vertex of an elliptical arc inscribed in a configured box for
// each vertex index requested.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration is written through wr_en / wr_index / wr_data, one register
//   per clock, while no request is in flight.
//   A request is taken at each rising edge with start high and busy low;
//   busy stays low, so a new vertex_index can be issued every cycle.
//   Each request yields exactly one result: point_x, point_y and saturated
//   are valid for the single cycle in which done is high, in request order.
//   The datapath holds the 31-stage restoring divider for index * span / count
//   and one cordic stage per iteration; throughput is one vertex per cycle.
//   The receiver has no way to hold results off and the pipeline never
//   stalls.
//   Reset clears the configuration to its defaults and drops any requests in
//   flight; no result appears until a new request has gone through.
// ----------------------------------------------------------------------------
module ellipse_arc_vertex_generator_unit #(
	parameter int MAX_POINTS   = eav_pkg::MAX_POINTS_DEF,
	parameter int CORDIC_STEPS = eav_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [eav_pkg::IDX_W-1:0]         vertex_index,
	output logic                                   done,
	output logic signed [eav_pkg::CRD_W-1:0]       point_x,
	output logic signed [eav_pkg::CRD_W-1:0]       point_y,
	output logic                                   saturated,
	input  wire logic                              wr_en,
	input  wire logic [eav_pkg::REG_W-1:0]         wr_index,
	input  wire logic [eav_pkg::DAT_W-1:0]         wr_data
);

	localparam int NSTEP   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int LATENCY = eav_pkg::SPAN_W + 6 + NSTEP + 4;
	localparam int CW      = eav_pkg::CW;
	localparam int IDX_W   = eav_pkg::IDX_W;
	localparam int SPAN_W  = eav_pkg::SPAN_W;

	logic [1:0] anchor_mode_q;
	logic signed [31:0] anchor_x_q, anchor_y_q;
	logic [30:0] box_width_q, box_height_q;
	logic [IDX_W-1:0] point_count_q;
	logic signed [31:0] start_angle_q, end_angle_q;

	logic [SPAN_W-1:0] span_q;
	logic signed [CW-1:0] cx2_q, cy2_q;

	logic ang_valid;
	logic signed [CW-1:0] ang_z;
	logic ang_neg;
	logic crd_valid;
	logic signed [CW-1:0] crd_x, crd_y;
	logic crd_neg;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_mode_q <= eav_pkg::MODE_ORIGIN;
			anchor_x_q    <= '0;
			anchor_y_q    <= '0;
			box_width_q   <= '0;
			box_height_q  <= '0;
			point_count_q <= IDX_W'(100);
			start_angle_q <= '0;
			end_angle_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				eav_pkg::REG_ANCHOR_MODE: anchor_mode_q <= wr_data[1:0];
				eav_pkg::REG_ANCHOR_X:    anchor_x_q    <= signed'(wr_data);
				eav_pkg::REG_ANCHOR_Y:    anchor_y_q    <= signed'(wr_data);
				eav_pkg::REG_BOX_WIDTH:   box_width_q   <= wr_data[30:0];
				eav_pkg::REG_BOX_HEIGHT:  box_height_q  <= wr_data[30:0];
				eav_pkg::REG_POINT_COUNT: point_count_q <= wr_data[IDX_W-1:0];
				eav_pkg::REG_START_ANGLE: start_angle_q <= signed'(wr_data);
				eav_pkg::REG_END_ANGLE:   end_angle_q   <= signed'(wr_data);
				default: ;
			endcase
		end
	end

	// span, full turn when empty or beyond one turn
	always_ff @(posedge clk) begin
		logic signed [32:0] d;
		d = 33'(end_angle_q) - 33'(start_angle_q);
		if (d <= 33'sd0 || 35'(d) > eav_pkg::TWO_PI_Q28) begin
			span_q <= SPAN_W'(eav_pkg::TWO_PI_Q28);
		end else begin
			span_q <= SPAN_W'(d);
		end
	end

	// doubled box centre, Q16.17
	always_ff @(posedge clk) begin
		case (anchor_mode_q)
			eav_pkg::MODE_BASE: begin
				cx2_q <= (CW'(anchor_x_q) <<< 1) + CW'(box_width_q);
				cy2_q <= (CW'(anchor_y_q) <<< 1) + CW'(box_height_q);
			end
			eav_pkg::MODE_CENTRE: begin
				cx2_q <= CW'(anchor_x_q) <<< 1;
				cy2_q <= CW'(anchor_y_q) <<< 1;
			end
			default: begin
				cx2_q <= CW'(box_width_q);
				cy2_q <= CW'(box_height_q);
			end
		endcase
	end

	assign busy = 1'b0;

	eav_angle #(
		.MAX_POINTS (MAX_POINTS)
	) u_angle (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start && !busy),
		.in_index    (vertex_index),
		.point_count (point_count_q),
		.span        (span_q),
		.start_angle (start_angle_q),
		.out_valid   (ang_valid),
		.out_z       (ang_z),
		.out_neg     (ang_neg)
	);

	eav_cordic #(
		.STEPS (NSTEP)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ang_valid),
		.in_z      (ang_z),
		.in_neg    (ang_neg),
		.out_valid (crd_valid),
		.out_x     (crd_x),
		.out_y     (crd_y),
		.out_neg   (crd_neg)
	);

	eav_coord u_coord (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (crd_valid),
		.in_x       (crd_x),
		.in_y       (crd_y),
		.in_neg     (crd_neg),
		.box_width  (box_width_q),
		.box_height (box_height_q),
		.centre_x2  (cx2_q),
		.centre_y2  (cy2_q),
		.out_valid  (done),
		.out_x      (point_x),
		.out_y      (point_y),
		.out_sat    (saturated)
	);

	// every request produces its result after the fixed latency
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("request without result");

	// no result without a matching request
	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without request");

	// folded cordic angle lies within a quarter turn
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		ang_valid |-> (ang_z <= 34'sd1686629712 && ang_z >= -34'sd1686629712))
		else $error("cordic angle out of range");

	// saturation flag only with a clamped coordinate
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (point_x == 32'sh7fffffff || point_y == 32'sh7fffffff
			|| point_x == -32'sh80000000 || point_y == -32'sh80000000))
		else $error("saturation flag without clamped value");

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the elliptical arc vertex generator against an independent fixed
// point model of the arc: directed corner vertices, then random runs of
// vertex requests across many box, anchor, count and angle settings.
// ----------------------------------------------------------------------------

// keeps the register copy, predicts each vertex and checks results in order
class arc_vertex_board;
	logic [1:0]          mode;
	logic signed [63:0]  ax, ay, a_start, a_end;
	logic [30:0]         width, height;
	logic [12:0]         count;
	logic [31:0]         want_x[$];
	logic [31:0]         want_y[$];
	logic                want_sat[$];
	int                  errors;
	int                  checked;

	function new();
		mode = eav_pkg::MODE_ORIGIN;
		ax = 0; ay = 0; width = 0; height = 0; count = 100;
		a_start = 0; a_end = 0; errors = 0; checked = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] d);
		case (idx)
			eav_pkg::REG_ANCHOR_MODE: mode = d[1:0];
			eav_pkg::REG_ANCHOR_X:    ax = $signed(d);
			eav_pkg::REG_ANCHOR_Y:    ay = $signed(d);
			eav_pkg::REG_BOX_WIDTH:   width = d[30:0];
			eav_pkg::REG_BOX_HEIGHT:  height = d[30:0];
			eav_pkg::REG_POINT_COUNT: count = d[12:0];
			eav_pkg::REG_START_ANGLE: a_start = $signed(d);
			default:                  a_end = $signed(d);
		endcase
	endfunction

	// arithmetic shift right on 64 bits
	function logic signed [63:0] sra(logic signed [63:0] v, int s);
		return v >>> s;
	endfunction

	// one coordinate: centre in Q16.17 plus rounded radius term, then clamp
	function logic [31:0] place(logic signed [63:0] anc, logic [30:0] ext,
			logic signed [63:0] trig, inout logic sat);
		logic signed [63:0] w, ctr, term, v;
		w = {33'd0, ext};
		if (mode == eav_pkg::MODE_BASE) ctr = 2 * anc + w;
		else if (mode == eav_pkg::MODE_CENTRE) ctr = 2 * anc;
		else ctr = w;
		term = sra(w * trig + (64'sd1 <<< 29), 30);
		v = sra(ctr + term + 1, 1);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			v = 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			sat = 1'b1;
			v = -64'sd2147483648;
		end
		return v[31:0];
	endfunction

	function void note_request(logic [12:0] vidx);
		logic signed [63:0] n, i, span, ang, r, x, y, z, nx;
		logic sat, flip;
		n = {51'd0, count};
		i = {51'd0, vidx};
		span = a_end - a_start;
		if (n < 1) n = 1;
		if (n > 4096) n = 4096;
		if (i >= n) i = 0;
		if (span <= 0 || span > 64'sd1686629713) span = 64'sd1686629713;
		ang = a_start + (i * span + n / 2) / n;
		// reduce into [-pi, pi], fold into [-pi/2, pi/2]
		r = ang % 64'sd1686629713;
		if (r < 0) r += 64'sd1686629713;
		if (r > 64'sd843314857) r -= 64'sd1686629713;
		flip = 1'b0;
		if (r > 64'sd421657428) begin
			r -= 64'sd843314857;
			flip = 1'b1;
		end else if (r < -64'sd421657428) begin
			r += 64'sd843314857;
			flip = 1'b1;
		end
		x = 64'sd652032874; y = 0; z = r * 4;
		for (int k = 0; k < 24; k++) begin
			if (z >= 0) begin
				nx = x - sra(y, k);
				y = y + sra(x, k);
				z -= $signed({32'd0, eav_pkg::atan_q30(k)});
			end else begin
				nx = x + sra(y, k);
				y = y - sra(x, k);
				z += $signed({32'd0, eav_pkg::atan_q30(k)});
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		sat = 1'b0;
		want_x.push_back(place(ax, width, x, sat));
		want_y.push_back(place(ay, height, y, sat));
		want_sat.push_back(sat);
	endfunction

	function void check_result(logic [31:0] px, logic [31:0] py, logic s);
		logic [31:0] ex, ey;
		logic es;
		if (want_x.size() == 0) begin
			$display("%0t: result with no request pending x=%h y=%h", $time, px, py);
			errors++;
			return;
		end
		ex = want_x.pop_front(); ey = want_y.pop_front(); es = want_sat.pop_front();
		checked++;
		if (px !== ex) begin
			$display("%0t: point_x expected %h actual %h", $time, ex, px);
			errors++;
		end
		if (py !== ey) begin
			$display("%0t: point_y expected %h actual %h", $time, ey, py);
			errors++;
		end
		if (s !== es) begin
			$display("%0t: saturated expected %b actual %b", $time, es, s);
			errors++;
		end
	endfunction

	function int pending();
		return want_x.size();
	endfunction
endclass

module testbench;
	logic        clk, arst_n, start, busy, done, saturated, wr_en;
	logic [12:0] vertex_index;
	logic [31:0] point_x, point_y, wr_data;
	logic [2:0]  wr_index;
	longint      cycles;
	int          gap_pct;
	int          sent;
	arc_vertex_board board;

	ellipse_arc_vertex_generator_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vertex_index(vertex_index), .done(done), .point_x(point_x),
		.point_y(point_y), .saturated(saturated), .wr_en(wr_en),
		.wr_index(wr_index), .wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result checking and cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) board.check_result(point_x, point_y, saturated);
		if (cycles > 400000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// write enable stays high across back to back writes
	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		wr_en <= 1'b1; wr_index <= idx; wr_data <= d;
		@(negedge clk);
		board.write_reg(idx, d);
	endtask

	// drains the pipeline before touching the registers
	task automatic wait_idle();
		start <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// start stays high into the next request when no gap is drawn
	task automatic request(logic [12:0] vidx);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		vertex_index <= vidx;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_request(vidx);
		sent++;
		@(negedge clk);
	endtask

	task automatic configure(logic [1:0] m, logic [31:0] x, logic [31:0] y,
			logic [31:0] w, logic [31:0] h, logic [31:0] n,
			logic [31:0] a0, logic [31:0] a1);
		wait_idle();
		write_reg(eav_pkg::REG_ANCHOR_MODE, {30'd0, m});
		write_reg(eav_pkg::REG_ANCHOR_X, x);
		write_reg(eav_pkg::REG_ANCHOR_Y, y);
		write_reg(eav_pkg::REG_BOX_WIDTH, w);
		write_reg(eav_pkg::REG_BOX_HEIGHT, h);
		write_reg(eav_pkg::REG_POINT_COUNT, n);
		write_reg(eav_pkg::REG_START_ANGLE, a0);
		write_reg(eav_pkg::REG_END_ANGLE, a1);
		wr_en <= 1'b0;
	endtask

	// random index mostly in range, sometimes at or beyond the count
	function automatic logic [12:0] pick_index();
		int c;
		c = board.count == 0 ? 1 : board.count;
		case ($urandom_range(9))
			0: return 13'($urandom);
			1: return 13'(c);
			default: return 13'($urandom_range(c - 1));
		endcase
	endfunction

	initial begin
		logic [31:0] rw, rh, rn;
		board = new();
		cycles = 0; sent = 0; gap_pct = 0;
		arst_n = 1'b0; start = 1'b0; vertex_index = '0;
		wr_en = 1'b0; wr_index = '0; wr_data = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset defaults: zero box at origin, full circle
		request(0);
		request(25);
		// directed corners: huge boxes, extreme anchors, every mode
		configure(eav_pkg::MODE_BASE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF, 8, 32'h80000000, 32'h7FFFFFFF);
		for (int i = 0; i < 9; i++) request(13'(i));
		request(13'h1FFF);
		configure(eav_pkg::MODE_CENTRE, 32'h80000000, 32'h7FFFFFFF, 32'h00010000,
			32'h00020000, 0, 32'h10000000, 32'h08000000);
		request(0); request(1);
		configure(2'd3, 32'h12345678, 32'h9ABCDEF0, 32'h00640000, 32'h00320000,
			13'h1FFF, 32'h00000000, 32'h3243F6A9);
		request(0); request(4095); request(4096); request(13'h1FFF);
		configure(eav_pkg::MODE_ORIGIN, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 4096,
			32'h7FFFFFFF, 32'h80000000);
		request(1); request(2048); request(4095);
		// hold off until the pipeline is empty
		wait_idle();

		// random settings, each with a burst of requests
		for (int ph = 0; ph < 28; ph++) begin
			rw = (ph % 5 == 0) ? $urandom : $urandom_range(32'h01000000);
			rh = (ph % 7 == 0) ? $urandom : $urandom_range(32'h01000000);
			rn = (ph % 9 == 0) ? $urandom : $urandom_range(1, 200);
			configure(2'($urandom), $urandom, $urandom, rw, rh, rn,
				(ph % 2) ? $urandom : $urandom_range(32'h20000000),
				(ph % 3) ? $urandom : $urandom_range(32'h70000000));
			gap_pct = (ph == 10) ? 0 : 21;
			for (int k = 0; k < 50; k++) request(pick_index());
		end

		start <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		$display("covered %0d vertex requests over 32 register settings, %0d results checked",
			sent, board.checked);
		if (board.errors == 0 && board.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
